[src/rpd_pkg.sv]
package rpd_pkg;

  localparam int CoordWidth = 24;
  localparam int MaxDims    = 4;
  localparam int DistWidth  = 26;
  localparam int CfgIdxWidth = 2;

  // 2*pi and pi in Q12, rounded to nearest
  localparam logic [14:0] TwoPiQ12 = 15'd25736;
  localparam logic [14:0] PiQ12    = 15'd12868;

  typedef enum logic [1:0] {
    NORM_MANHATTAN = 2'd0,
    NORM_EUCLIDEAN = 2'd1,
    NORM_SUPREMUM  = 2'd2,
    NORM_MODULATED = 2'd3
  } norm_mode_t;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_NORM_MODE = 2'd0,
    REG_DIMS      = 2'd1,
    REG_THRESHOLD = 2'd2,
    REG_UNUSED    = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic signed [CoordWidth-1:0] p_0;
    logic signed [CoordWidth-1:0] p_1;
    logic signed [CoordWidth-1:0] p_2;
    logic signed [CoordWidth-1:0] p_3;
    logic signed [CoordWidth-1:0] q_0;
    logic signed [CoordWidth-1:0] q_1;
    logic signed [CoordWidth-1:0] q_2;
    logic signed [CoordWidth-1:0] q_3;
  } point_pair_t;

  typedef struct packed {
    logic [DistWidth-1:0] distance;
    logic                 recurrent;
  } result_t;

endpackage

[src/recurrence_pair_distance_unit.sv]
// Recurrence pair distance unit.
// Input channel (in_valid/in_ready/in_data): one item is a pair of points p, q
// with four signed Q11.12 coordinates each. Output channel (out_valid/
// out_ready/out_data): the distance in unsigned Q12 under the selected norm,
// and a recurrence bit set when the distance is strictly below threshold.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): 0 norm mode,
// 1 coordinates in use, 2 threshold; other indexes are dropped. cfg_ready is
// always high; write only while no item is in flight.
// Throughput: one item per cycle while the receiver does not stall. Stages at
// default widths: input reg, then abs diff, reciprocal multiply, remainder
// multiply, fold, square, sum, 25 root stages, output reg.
// The depth is set by the square root, one result bit per stage.
// Reset (rst, synchronous) clears all valid bits and loads the register
// defaults: Manhattan, four coordinates, threshold zero.
// When the receiver stalls, the whole pipeline freezes and in_ready drops in
// the same cycle; nothing is lost or repeated.
module recurrence_pair_distance_unit (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  rpd_pkg::point_pair_t                     in_data,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output rpd_pkg::result_t                         out_data,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [rpd_pkg::CfgIdxWidth-1:0]          cfg_index,
  input  logic [rpd_pkg::DistWidth-1:0]            cfg_data
);

  localparam int W   = rpd_pkg::CoordWidth;
  localparam int N   = rpd_pkg::MaxDims;
  localparam int E   = $clog2(N);
  localparam int SW  = 2 * W + E;          // full sum of squares
  localparam int AW  = (SW > 64) ? 64 : SW; // saturated accumulator
  localparam int XW  = AW + (AW % 2);
  localparam int RW  = XW / 2;             // root bits = root stages
  localparam int MW  = W + E;              // Manhattan sum
  localparam int CW  = 15;
  localparam int S   = W + 16;             // reciprocal shift
  localparam int MRW = S - 13;
  localparam logic [63:0] Recip = (64'd1 << S) / 64'd25736;
  localparam int DW  = rpd_pkg::DistWidth;
  localparam logic [63:0] DistMax = (64'd1 << DW) - 64'd1;

  // config registers
  logic [1:0]    norm_mode;
  logic [2:0]    dims_in_use;
  logic [DW-1:0] threshold;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      norm_mode   <= rpd_pkg::NORM_MANHATTAN;
      dims_in_use <= 3'd4;
      threshold   <= '0;
    end else if (cfg_valid) begin
      unique case (rpd_pkg::reg_index_t'(cfg_index))
        rpd_pkg::REG_NORM_MODE: norm_mode   <= cfg_data[1:0];
        rpd_pkg::REG_DIMS:      dims_in_use <= cfg_data[2:0];
        rpd_pkg::REG_THRESHOLD: threshold   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic is_mod, is_sqrt;
  assign is_mod  = (norm_mode == rpd_pkg::NORM_MODULATED);
  assign is_sqrt = (norm_mode == rpd_pkg::NORM_EUCLIDEAN) || is_mod;

  // clamp dims to [1, N]
  logic [3:0] dims_eff;
  always_comb begin
    if (dims_in_use == 3'd0) dims_eff = 4'd1;
    else if ({1'b0, dims_in_use} > 4'(N)) dims_eff = 4'(N);
    else dims_eff = {1'b0, dims_in_use};
  end

  // global advance: the pipeline moves unless the output is held
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // stage 0: input register
  logic v0, v1, v2, v3, v4, v5, v6;
  logic [W-1:0] pa0 [N];
  logic [W-1:0] qa0 [N];
  logic [W-1:0] pin [N];
  logic [W-1:0] qin [N];

  always_comb begin
    pin[0] = in_data.p_0; pin[1] = in_data.p_1;
    pin[2] = in_data.p_2; pin[3] = in_data.p_3;
    qin[0] = in_data.q_0; qin[1] = in_data.q_1;
    qin[2] = in_data.q_2; qin[3] = in_data.q_3;
  end

  logic [W-1:0]       d1 [N];
  logic [W-1:0]       d2 [N];
  logic [W-1:0]       qe2 [N];
  logic [W-1:0]       d3 [N];
  logic [W+CW-1:0]    pr3 [N];
  logic [W-1:0]       m4 [N];
  logic [2*W-1:0]     sq5 [N];
  logic [W-1:0]       m5 [N];
  logic [AW-1:0]      acc6;

  logic [W-1:0]       d1_next [N];
  logic [W-1:0]       m4_next [N];
  logic [AW-1:0]      acc6_next;

  // abs difference, offset binary keeps order; idle lanes read as zero
  always_comb begin
    logic [W-1:0] x, y;
    for (int k = 0; k < N; k++) begin
      x = pa0[k] ^ {1'b1, {(W-1){1'b0}}};
      y = qa0[k] ^ {1'b1, {(W-1){1'b0}}};
      if (4'(k) >= dims_eff) d1_next[k] = '0;
      else d1_next[k] = (x > y) ? x - y : y - x;
    end
  end

  // |d| mod 2pi with fold above pi, or |d| unchanged
  always_comb begin
    logic [W+CW-1:0] r0, r1, r2;
    for (int k = 0; k < N; k++) begin
      r0 = (W+CW)'(d3[k]) - pr3[k];
      r1 = (r0 >= (W+CW)'(rpd_pkg::TwoPiQ12)) ? r0 - (W+CW)'(rpd_pkg::TwoPiQ12) : r0;
      r2 = (r1 > (W+CW)'(rpd_pkg::PiQ12)) ? (W+CW)'(rpd_pkg::TwoPiQ12) - r1 : r1;
      m4_next[k] = is_mod ? r2[W-1:0] : d3[k];
    end
  end

  // lane reduction, sum of squares saturates at 2^AW-1 (AW is SW capped at 64)
  always_comb begin
    logic [SW-1:0] sumsq;
    logic [MW-1:0] summ;
    logic [W-1:0]  maxd;
    sumsq = '0;
    summ  = '0;
    maxd  = '0;
    for (int k = 0; k < N; k++) begin
      sumsq = sumsq + SW'(sq5[k]);
      summ  = summ + MW'(m5[k]);
      if (m5[k] > maxd) maxd = m5[k];
    end
    case (norm_mode)
      rpd_pkg::NORM_MANHATTAN: acc6_next = AW'(summ);
      rpd_pkg::NORM_SUPREMUM:  acc6_next = AW'(maxd);
      default: begin
        if ((SW > AW) && ((65'(sumsq) >> AW) != 65'd0)) acc6_next = '1;
        else acc6_next = sumsq[AW-1:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      {v0, v1, v2, v3, v4, v5, v6} <= '0;
    end else if (adv) begin
      {v0, v1, v2, v3, v4, v5, v6} <= {in_valid, v0, v1, v2, v3, v4, v5};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < N; k++) begin
        pa0[k] <= pin[k];
        qa0[k] <= qin[k];
        d1[k]  <= d1_next[k];
        // floor reciprocal gives the quotient or one less
        qe2[k] <= W'(((W+MRW)'(d1[k]) * (W+MRW)'(Recip)) >> S);
        d2[k]  <= d1[k];
        pr3[k] <= (W+CW)'(qe2[k]) * (W+CW)'(rpd_pkg::TwoPiQ12);
        d3[k]  <= d2[k];
        m4[k]  <= m4_next[k];
        sq5[k] <= (2*W)'(m4[k]) * (2*W)'(m4[k]);
        m5[k]  <= m4[k];
      end
      acc6 <= acc6_next;
    end
  end

  // square root, one result bit per stage (restoring)
  logic            sv   [RW+1];
  logic [RW+1:0]   srem [RW+1];
  logic [RW-1:0]   sroot[RW+1];
  logic [XW-1:0]   sx   [RW+1];
  logic [AW-1:0]   sacc [RW+1];
  logic [RW+1:0]   srem_next  [RW];
  logic [RW-1:0]   sroot_next [RW];

  always_comb begin
    sv[0]    = v6;
    srem[0]  = '0;
    sroot[0] = '0;
    sx[0]    = XW'(acc6);
    sacc[0]  = acc6;
  end

  always_comb begin
    logic [RW+1:0] rs, trial;
    for (int i = 0; i < RW; i++) begin
      rs    = {srem[i][RW-1:0], sx[i][XW-1:XW-2]};
      trial = {sroot[i], 2'b01};
      if (rs >= trial) begin
        srem_next[i]  = rs - trial;
        sroot_next[i] = {sroot[i][RW-2:0], 1'b1};
      end else begin
        srem_next[i]  = rs;
        sroot_next[i] = {sroot[i][RW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < RW; i++) begin
      if (rst) begin
        sv[i+1] <= 1'b0;
      end else if (adv) begin
        sv[i+1] <= sv[i];
      end
      if (adv) begin
        srem[i+1]  <= srem_next[i];
        sroot[i+1] <= sroot_next[i];
        sx[i+1]    <= sx[i] << 2;
        sacc[i+1]  <= sacc[i];
      end
    end
  end

  // output register with distance saturation and threshold compare
  logic [63:0]   dist_wide;
  logic [DW-1:0] dist_sat;
  assign dist_wide = is_sqrt ? 64'(sroot[RW]) : 64'(sacc[RW]);
  assign dist_sat  = (dist_wide > DistMax) ? DistMax[DW-1:0] : dist_wide[DW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= sv[RW];
    end
    if (adv) begin
      out_data.distance  <= dist_sat;
      out_data.recurrent <= (dist_sat < threshold);
    end
  end

  a_ready_rule: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow output stall");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_recur_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.recurrent == (out_data.distance < threshold)))
    else $error("recurrence bit disagrees with distance");

  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    (sv[RW] && out_valid && !out_ready) |=> sv[RW])
    else $error("last root stage lost an item during stall");

endmodule

[bench/tb_recurrence_pair_distance_unit.sv]
module tb_recurrence_pair_distance_unit;

  // Pipeline depth of the block; drain margin on top.
  localparam int PipeDepth = 32;
  localparam int DrainCycles = PipeDepth + 20;
  localparam int RandomPairs = 450;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  rpd_pkg::point_pair_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rpd_pkg::result_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [rpd_pkg::CfgIdxWidth-1:0] cfg_index = '0;
  logic [rpd_pkg::DistWidth-1:0] cfg_data = '0;

  recurrence_pair_distance_unit dut (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always #4 clk = ~clk;

  // Shadow copy of the register file.
  rpd_pkg::norm_mode_t shadow_norm = rpd_pkg::NORM_MANHATTAN;
  logic [2:0] shadow_dims = 3'd4;
  logic [rpd_pkg::DistWidth-1:0] shadow_thresh = '0;

  rpd_pkg::result_t pending_results[$];
  int errors = 0;
  int pairs_sent = 0;
  int results_seen = 0;
  int norm_hits[4] = '{0, 0, 0, 0};
  bit stall_free = 1'b0;  // long stretch with no idling on either side

  // Offset-binary compare keeps the difference exact and unsigned.
  function automatic logic [rpd_pkg::CoordWidth-1:0] coord_gap(
      logic [rpd_pkg::CoordWidth-1:0] a, logic [rpd_pkg::CoordWidth-1:0] b);
    logic [rpd_pkg::CoordWidth-1:0] x, y;
    x = a ^ {1'b1, {(rpd_pkg::CoordWidth - 1){1'b0}}};
    y = b ^ {1'b1, {(rpd_pkg::CoordWidth - 1){1'b0}}};
    return (x > y) ? x - y : y - x;
  endfunction

  function automatic logic [63:0] floor_root(logic [63:0] v);
    logic [63:0] r, t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic rpd_pkg::result_t predict_distance(rpd_pkg::point_pair_t pr);
    logic [rpd_pkg::CoordWidth-1:0] pc[4], qc[4];
    logic [63:0] acc, d, rem;
    int n;
    rpd_pkg::result_t res;
    pc = '{pr.p_0, pr.p_1, pr.p_2, pr.p_3};
    qc = '{pr.q_0, pr.q_1, pr.q_2, pr.q_3};
    n = (shadow_dims == 0) ? 1 :
        (shadow_dims > rpd_pkg::MaxDims) ? rpd_pkg::MaxDims : shadow_dims;
    acc = 0;
    for (int k = 0; k < n; k++) begin
      d = 64'(coord_gap(pc[k], qc[k]));
      case (shadow_norm)
        rpd_pkg::NORM_MANHATTAN: acc = acc + d;
        rpd_pkg::NORM_EUCLIDEAN: acc = acc + d * d;
        rpd_pkg::NORM_SUPREMUM: if (d > acc) acc = d;
        default: begin
          rem = d % 64'(rpd_pkg::TwoPiQ12);
          if (rem > 64'(rpd_pkg::PiQ12)) rem = 64'(rpd_pkg::TwoPiQ12) - rem;
          acc = acc + rem * rem;
        end
      endcase
    end
    if (shadow_norm == rpd_pkg::NORM_EUCLIDEAN || shadow_norm == rpd_pkg::NORM_MODULATED)
      acc = floor_root(acc);
    if (acc > 64'((1 << rpd_pkg::DistWidth) - 1)) acc = 64'((1 << rpd_pkg::DistWidth) - 1);
    res.distance = acc[rpd_pkg::DistWidth-1:0];
    res.recurrent = (acc < 64'(shadow_thresh));
    return res;
  endfunction

  function automatic logic [rpd_pkg::CoordWidth-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return {1'b1, {(rpd_pkg::CoordWidth - 1){1'b0}}};
      1: return {1'b0, {(rpd_pkg::CoordWidth - 1){1'b1}}};
      2: return rpd_pkg::CoordWidth'($signed($urandom_range(0, 60000)) - 30000);
      default: return rpd_pkg::CoordWidth'($urandom);
    endcase
  endfunction

  // Leaves cfg_valid high; the caller drops it after the last write.
  task automatic write_reg(rpd_pkg::reg_index_t idx, logic [rpd_pkg::DistWidth-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      rpd_pkg::REG_NORM_MODE: shadow_norm = rpd_pkg::norm_mode_t'(val[1:0]);
      rpd_pkg::REG_DIMS: shadow_dims = val[2:0];
      rpd_pkg::REG_THRESHOLD: shadow_thresh = val;
      default: ;  // dropped by the block
    endcase
    @(negedge clk);
  endtask

  task automatic write_setting(rpd_pkg::norm_mode_t nm, logic [2:0] dm,
                               logic [rpd_pkg::DistWidth-1:0] th);
    write_reg(rpd_pkg::REG_NORM_MODE, rpd_pkg::DistWidth'(nm));
    write_reg(rpd_pkg::REG_DIMS, rpd_pkg::DistWidth'(dm));
    write_reg(rpd_pkg::REG_THRESHOLD, th);
    cfg_valid <= 1'b0;
  endtask

  // Configuration changes only with the pipeline empty.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (PipeDepth + 4) @(negedge clk);
  endtask

  // Sends one pair; a known answer overrides the predictor when given.
  // in_valid stays high on return; the caller drops it before any wait.
  task automatic send_pair(rpd_pkg::point_pair_t pr, bit known,
                           rpd_pkg::result_t known_res);
    if (!stall_free)
      while ($urandom_range(0, 99) < 16) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    in_valid <= 1'b1;
    in_data <= pr;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(known ? known_res : predict_distance(pr));
    norm_hits[shadow_norm]++;
    pairs_sent++;
    @(negedge clk);
  endtask

  // Receiver: random stalls, checks against the oldest expectation.
  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= stall_free || ($urandom_range(0, 99) >= 16);
  end

  always @(posedge clk) begin
    rpd_pkg::result_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: distance %0d", out_data.distance);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.distance !== want.distance) begin
          $error("distance: expected %0d, got %0d", want.distance, out_data.distance);
          errors++;
        end
        if (out_data.recurrent !== want.recurrent) begin
          $error("recurrent: expected %0b, got %0b", want.recurrent, out_data.recurrent);
          errors++;
        end
      end
    end
  end

  typedef struct {
    rpd_pkg::norm_mode_t norm;
    logic [2:0] dims;
    logic [rpd_pkg::DistWidth-1:0] thresh;
    rpd_pkg::point_pair_t pr;
    bit known;
    rpd_pkg::result_t res;
  } directed_row_t;

  localparam logic [rpd_pkg::CoordWidth-1:0] CMin =
    {1'b1, {(rpd_pkg::CoordWidth - 1){1'b0}}};
  localparam logic [rpd_pkg::CoordWidth-1:0] CMax =
    {1'b0, {(rpd_pkg::CoordWidth - 1){1'b1}}};
  localparam logic [rpd_pkg::DistWidth-1:0] DMax = {rpd_pkg::DistWidth{1'b1}};

  directed_row_t directed_rows[$];

  task automatic add_row(rpd_pkg::norm_mode_t nm, logic [2:0] dm,
                         logic [rpd_pkg::DistWidth-1:0] th,
                         rpd_pkg::point_pair_t pr, bit known, rpd_pkg::result_t res);
    directed_row_t row;
    row = '{nm, dm, th, pr, known, res};
    directed_rows.push_back(row);
  endtask

  initial begin
    rpd_pkg::point_pair_t pr;
    rpd_pkg::point_pair_t zero_pair, span_pair;
    rpd_pkg::result_t dc;
    rpd_pkg::norm_mode_t nm;
    logic [2:0] dm;
    logic [rpd_pkg::DistWidth-1:0] th;
    dc = '0;
    zero_pair = '0;
    span_pair = '{CMax, CMax, CMax, CMax, CMin, CMin, CMin, CMin};

    // Directed table. Full span gap per coordinate is 2^24-1.
    add_row(rpd_pkg::NORM_MANHATTAN, 3'd4, '0, zero_pair, 1, '{26'd0, 1'b0});
    add_row(rpd_pkg::NORM_MANHATTAN, 3'd4, 26'd1, zero_pair, 1, '{26'd0, 1'b1});
    add_row(rpd_pkg::NORM_MANHATTAN, 3'd4, DMax, span_pair, 1, '{26'd67108860, 1'b1});
    add_row(rpd_pkg::NORM_SUPREMUM, 3'd4, 26'd16777215, span_pair, 1,
            '{26'd16777215, 1'b0});
    add_row(rpd_pkg::NORM_SUPREMUM, 3'd4, 26'd16777216, span_pair, 1,
            '{26'd16777215, 1'b1});
    add_row(rpd_pkg::NORM_EUCLIDEAN, 3'd4, DMax, span_pair, 1, '{26'd33554430, 1'b1});
    add_row(rpd_pkg::NORM_EUCLIDEAN, 3'd1, '0, span_pair, 1, '{26'd16777215, 1'b0});
    // Dims zero acts as one, dims above four act as four.
    add_row(rpd_pkg::NORM_MANHATTAN, 3'd0, '0, span_pair, 1, '{26'd16777215, 1'b0});
    add_row(rpd_pkg::NORM_MANHATTAN, 3'd7, '0, span_pair, 1, '{26'd67108860, 1'b0});
    add_row(rpd_pkg::NORM_MANHATTAN, 3'd5, '0, span_pair, 0, dc);
    // Modulated: gap of exactly pi stays, just above pi folds, 2*pi wraps to 0.
    pr = '0; pr.p_0 = 24'sd12868;
    add_row(rpd_pkg::NORM_MODULATED, 3'd1, '0, pr, 1, '{26'd12868, 1'b0});
    pr.p_0 = 24'sd12869;
    add_row(rpd_pkg::NORM_MODULATED, 3'd1, '0, pr, 1, '{26'd12867, 1'b0});
    pr.p_0 = 24'sd25736;
    add_row(rpd_pkg::NORM_MODULATED, 3'd1, 26'd1, pr, 1, '{26'd0, 1'b1});
    pr.p_0 = -24'sd25737;
    add_row(rpd_pkg::NORM_MODULATED, 3'd1, '0, pr, 1, '{26'd1, 1'b0});
    add_row(rpd_pkg::NORM_MODULATED, 3'd4, DMax, span_pair, 0, dc);
    add_row(rpd_pkg::NORM_EUCLIDEAN, 3'd2, 26'd5000, '{24'sd3, -24'sd4, 24'sd9, 24'sd9,
            24'sd0, 24'sd0, 24'sd1, 24'sd1}, 1, '{26'd5, 1'b1});
    add_row(rpd_pkg::NORM_SUPREMUM, 3'd3, 26'd100, '{-24'sd50, 24'sd7, 24'sd70, 24'sd0,
            24'sd50, 24'sd7, -24'sd30, 24'sd999}, 0, dc);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // After reset: Manhattan, four dims, threshold zero.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].norm != shadow_norm || directed_rows[i].dims != shadow_dims
          || directed_rows[i].thresh != shadow_thresh) begin
        wait_drained();
        write_setting(directed_rows[i].norm, directed_rows[i].dims,
                      directed_rows[i].thresh);
      end
      send_pair(directed_rows[i].pr, directed_rows[i].known, directed_rows[i].res);
    end

    // An unused index must leave every register alone.
    wait_drained();
    write_reg(rpd_pkg::REG_UNUSED, DMax);
    cfg_valid <= 1'b0;
    send_pair(span_pair, 0, dc);

    // Random phases: each picks a setting, then a burst of pairs.
    for (int phase = 0; phase < 15; phase++) begin
      wait_drained();
      nm = rpd_pkg::norm_mode_t'(phase % 4);
      dm = (phase < 8) ? 3'($urandom_range(1, 4)) : 3'($urandom_range(0, 7));
      case ($urandom_range(0, 3))
        0: th = '0;
        1: th = DMax;
        default: th = rpd_pkg::DistWidth'($urandom_range(0, 1 << 24));
      endcase
      write_setting(nm, dm, th);
      stall_free = (phase == 6);
      for (int n = 0; n < RandomPairs / 15; n++) begin
        pr = '{rand_coord(), rand_coord(), rand_coord(), rand_coord(),
               rand_coord(), rand_coord(), rand_coord(), rand_coord()};
        // Nearby pairs exercise the threshold boundary.
        if ($urandom_range(0, 3) == 0) begin
          pr.q_0 = pr.p_0 + rpd_pkg::CoordWidth'($urandom_range(0, 40000));
          pr.q_1 = pr.p_1 - rpd_pkg::CoordWidth'($urandom_range(0, 40000));
        end
        send_pair(pr, 0, dc);
        // Hold off mid-phase until the pipeline empties once.
        if (phase == 3 && n == 10) begin
          in_valid <= 1'b0;
          while (pending_results.size() != 0) @(negedge clk);
        end
      end
      stall_free = 1'b0;
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);

    $display("sent %0d pairs, checked %0d results", pairs_sent, results_seen);
    $display("per norm: manhattan %0d, euclidean %0d, supremum %0d, modulated %0d",
             norm_hits[0], norm_hits[1], norm_hits[2], norm_hits[3]);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: far past the slowest legal run.
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule

[filelist.f]
src/rpd_pkg.sv
src/recurrence_pair_distance_unit.sv
bench/tb_recurrence_pair_distance_unit.sv
